// File: rtl/core/snfcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SPI NOR command sequencer package
// Shared constants, flash opcodes and the types passed between the front end,
// the descriptor queue and the frame generator.
// ----------------------------------------------------------------------------
package snfcs_pkg;

	// Defaults for the top-level parameters.
	localparam int PAGE_BYTES_DEF   = 256;
	localparam int ADDRESS_BITS_DEF = 24;

	// Descriptor queue depth.
	localparam int QUEUE_DEPTH = 4;

	// Request operation codes.
	localparam logic [2:0] OPC_READ_ID     = 3'd0;
	localparam logic [2:0] OPC_UNIQUE_ID   = 3'd1;
	localparam logic [2:0] OPC_ERASE       = 3'd2;
	localparam logic [2:0] OPC_PROG_START  = 3'd3;
	localparam logic [2:0] OPC_PROG_DATA   = 3'd4;
	localparam logic [2:0] OPC_READ        = 3'd5;
	localparam logic [2:0] OPC_STATUS      = 3'd6;

	// Erase modes.
	localparam logic [1:0] ERASE_4K   = 2'd0;
	localparam logic [1:0] ERASE_32K  = 2'd1;
	localparam logic [1:0] ERASE_64K  = 2'd2;
	localparam logic [1:0] ERASE_CHIP = 2'd3;

	// Configuration register indexes.
	localparam logic REG_FAST_READ = 1'b0;
	localparam logic REG_BIT_REV   = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_MODE = 2'd1;
	localparam logic [1:0] ST_SEQ      = 2'd2;

	// Flash opcodes.
	localparam logic [7:0] FOP_WREN      = 8'h06;
	localparam logic [7:0] FOP_SE_4K     = 8'h20;
	localparam logic [7:0] FOP_BE_32K    = 8'h52;
	localparam logic [7:0] FOP_BE_64K    = 8'hD8;
	localparam logic [7:0] FOP_CE        = 8'hC7;
	localparam logic [7:0] FOP_PP        = 8'h02;
	localparam logic [7:0] FOP_RDSR      = 8'h05;
	localparam logic [7:0] FOP_FAST_READ = 8'h0B;
	localparam logic [7:0] FOP_READ      = 8'h03;
	localparam logic [7:0] FOP_RDID      = 8'h9F;
	localparam logic [7:0] FOP_RUID      = 8'h4B;

	// Receive counts of the fixed commands.
	localparam logic [8:0] RX_RDSR = 9'd1;
	localparam logic [8:0] RX_RDID = 9'd3;
	localparam logic [8:0] RX_RUID = 9'd8;

	// Sequencing phase of the front end.
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_DATA,
		PH_POLL,
		PH_RDWAIT
	} phase_t;

	// What the front end decided for one accepted word.
	typedef enum logic [3:0] {
		ACT_RDID,
		ACT_UID,
		ACT_ERASE,
		ACT_PROG_START,
		ACT_READ_START,
		ACT_READ_NEXT,
		ACT_DATA,
		ACT_POLL_BUSY,
		ACT_PROG_NEXT,
		ACT_FIN,
		ACT_ERR
	} action_t;

	// Kind of frame sequence the back end expands.
	typedef enum logic [3:0] {
		K_ERR,
		K_FIN,
		K_POLL,
		K_RDID,
		K_UID,
		K_ERASE_CHIP,
		K_ERASE,
		K_PROG,
		K_READ,
		K_DATA
	} desc_kind_t;

	typedef struct packed {
		desc_kind_t  kind;
		logic [7:0]  opcode;     // command opcode, or the data byte
		logic [23:0] addr;
		logic [8:0]  rx;         // read chunk receive count
		logic        fin;        // read request ends with this chunk
		logic        dummy;      // fast read dummy byte follows the address
		logic        tail_poll;  // frame closes and a status poll follows
	} desc_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       frame_end;
		logic [8:0] rx_count;
		logic       done_res;
		logic [1:0] status_code;
		logic       last;
	} res_t;

	function automatic logic [7:0] erase_opcode(input logic [1:0] mode);
		logic [7:0] op;
		unique case (mode)
			ERASE_4K:  op = FOP_SE_4K;
			ERASE_32K: op = FOP_BE_32K;
			ERASE_64K: op = FOP_BE_64K;
			default:   op = FOP_CE;
		endcase
		return op;
	endfunction

	function automatic logic [7:0] rev8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = v[7 - i];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/snfcs_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SPI NOR command sequencer channels
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface snfcs_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [1:0]  erase_mode;
	logic [23:0] address;
	logic [23:0] length;
	logic [7:0]  data_byte;
	logic [7:0]  status_byte;

	modport source (output valid, operation, erase_mode, address, length, data_byte,
		status_byte, input ready);
	modport sink (input valid, operation, erase_mode, address, length, data_byte,
		status_byte, output ready);
endinterface

interface snfcs_res_if;
	logic       valid;
	logic       ready;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic       frame_end;
	logic [8:0] rx_count;
	logic       done_res;
	logic [1:0] status_code;
	logic       last;

	modport source (output valid, tx_valid, tx_byte, frame_end, rx_count, done_res,
		status_code, last, input ready);
	modport sink (input valid, tx_valid, tx_byte, frame_end, rx_count, done_res,
		status_code, last, output ready);
endinterface

interface snfcs_cfg_if;
	logic valid;
	logic ready;
	logic reg_index;
	logic reg_data;

	modport source (output valid, reg_index, reg_data, input ready);
	modport sink (input valid, reg_index, reg_data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/spi_nor_flash_command_sequencer_unit.sv
`default_nettype none
// Path: an accepted request word is written into the descriptor queue, and its first
// result word then passes through the frame generator's output register.
// Throughput: one request word per cycle while the descriptor queue has room, and
// one result word per cycle (up to six per request) unless res.ready stalls.
// Reset: arst_n clears the phase, bookkeeping, queue and output valid at once;
// fast read comes up enabled and bit reversal disabled.
// ----------------------------------------------------------------------------
// SPI NOR flash command sequencer
// Turns flash requests and status replies into the SPI frame bytes the flash
// must receive, with page-split program and read and busy polling.
// ----------------------------------------------------------------------------
module spi_nor_flash_command_sequencer_unit #(
	parameter int PAGE_BYTES   = snfcs_pkg::PAGE_BYTES_DEF,
	parameter int ADDRESS_BITS = snfcs_pkg::ADDRESS_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	snfcs_req_if.sink   req,
	snfcs_cfg_if.sink   cfg,
	snfcs_res_if.source res
);
	import snfcs_pkg::*;

	// The front end decides everything about a word in the cycle it is accepted:
	// it checks the word against the sequencing phase, works out the chunk that
	// ends at the next page boundary and updates address and length. Each
	// accepted word becomes exactly one descriptor, so the request channel is
	// ready whenever the queue has a free slot.
	logic  push;
	logic  full;
	desc_t push_desc;

	// The queue lets the front keep taking words while the frame generator is
	// held up by a slow consumer of result words.
	logic  head_valid;
	logic  pop;
	desc_t head;

	snfcs_front #(
		.PAGE_BYTES   (PAGE_BYTES),
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cfg    (cfg),
		.full   (full),
		.push   (push),
		.desc   (push_desc)
	);

	snfcs_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_desc    (push_desc),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// The frame generator steps through the head descriptor one word per cycle while
	// not stalled, into its output register, and releases it with its last word.
	snfcs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.res        (res)
	);

endmodule
`default_nettype wire

// File: rtl/core/snfcs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SPI NOR command sequencer front end
// Accepts request words, classifies them against the sequencing phase, keeps
// address and length bookkeeping and pushes one descriptor per word.
// ----------------------------------------------------------------------------
module snfcs_front #(
	parameter int PAGE_BYTES   = snfcs_pkg::PAGE_BYTES_DEF,
	parameter int ADDRESS_BITS = snfcs_pkg::ADDRESS_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	snfcs_req_if.sink          req,
	snfcs_cfg_if.sink          cfg,
	input  logic               full,
	output logic               push,
	output snfcs_pkg::desc_t   desc
);
	import snfcs_pkg::*;

	// Page size is a power of two, so the page offset is a mask.
	localparam int PW = $clog2(PAGE_BYTES);
	localparam int CW = $clog2(PAGE_BYTES + 1);
	localparam int AW = (ADDRESS_BITS > 24) ? 24 : ADDRESS_BITS;
	localparam logic [23:0] AMASK = {24{1'b1}} >> (24 - AW);

	phase_t        phase_q, phase_d;
	logic          prog_q;
	logic [23:0]   cur_q;
	logic [23:0]   rem_q;
	logic [CW-1:0] chunk_left_q;
	logic          fast_q;
	logic          bitrev_q;

	action_t       act;
	logic [23:0]   in_addr;
	logic [23:0]   base_addr;
	logic [23:0]   base_len;
	logic [PW-1:0] off;
	logic [24:0]   span;
	logic [CW-1:0] cnt;
	logic [23:0]   rem_after;
	logic [23:0]   addr_after;

	assign req.ready = !full;
	assign push      = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign in_addr   = req.address & AMASK;

	// Classify the word against the current phase.
	always_comb begin
		act = ACT_ERR;
		unique case (phase_q)
			PH_IDLE: begin
				if (req.operation == OPC_READ_ID)         act = ACT_RDID;
				else if (req.operation == OPC_UNIQUE_ID)  act = ACT_UID;
				else if (req.operation == OPC_ERASE)      act = ACT_ERASE;
				else if (req.operation == OPC_PROG_START) act = ACT_PROG_START;
				else if (req.operation == OPC_READ)       act = ACT_READ_START;
			end
			PH_RDWAIT: begin
				if (req.operation == OPC_READ) act = ACT_READ_NEXT;
			end
			PH_DATA: begin
				if (req.operation == OPC_PROG_DATA) act = ACT_DATA;
			end
			PH_POLL: begin
				if (req.operation == OPC_STATUS) begin
					if (req.status_byte[0])          act = ACT_POLL_BUSY;
					else if (prog_q && rem_q != '0)  act = ACT_PROG_NEXT;
					else                             act = ACT_FIN;
				end
			end
			default: act = ACT_ERR;
		endcase
	end

	// Chunk size up to the next page boundary.
	assign base_addr  = (phase_q == PH_IDLE) ? in_addr : cur_q;
	assign base_len   = (phase_q == PH_IDLE) ? req.length : rem_q;
	assign off        = base_addr[PW-1:0];
	assign span       = {1'b0, base_len} + 25'(off);
	assign cnt        = (span > 25'(PAGE_BYTES)) ? (CW'(PAGE_BYTES) - CW'(off))
		: CW'(base_len);
	assign rem_after  = base_len - 24'(cnt);
	assign addr_after = (base_addr + 24'(cnt)) & AMASK;

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		unique case (act) inside
			ACT_ERASE, ACT_POLL_BUSY: phase_d = PH_POLL;
			ACT_PROG_START, ACT_PROG_NEXT: phase_d = (cnt == '0) ? PH_POLL : PH_DATA;
			ACT_READ_START, ACT_READ_NEXT: phase_d = (rem_after == '0) ? PH_IDLE : PH_RDWAIT;
			ACT_DATA: phase_d = (chunk_left_q == CW'(1)) ? PH_POLL : PH_DATA;
			ACT_FIN: phase_d = PH_IDLE;
			default: phase_d = phase_q;
		endcase
	end

	// Descriptor for the back end.
	always_comb begin
		desc           = '0;
		desc.kind      = K_ERR;
		desc.addr      = base_addr;
		desc.rx        = 9'(cnt);
		desc.dummy     = fast_q;
		desc.fin       = (rem_after == '0);
		desc.tail_poll = (cnt == '0);
		unique case (act) inside
			ACT_RDID: desc.kind = K_RDID;
			ACT_UID:  desc.kind = K_UID;
			ACT_ERASE: begin
				desc.kind   = (req.erase_mode == ERASE_CHIP) ? K_ERASE_CHIP : K_ERASE;
				desc.opcode = erase_opcode(req.erase_mode);
			end
			ACT_PROG_START, ACT_PROG_NEXT: desc.kind = K_PROG;
			ACT_READ_START, ACT_READ_NEXT: begin
				desc.kind   = K_READ;
				desc.opcode = fast_q ? FOP_FAST_READ : FOP_READ;
			end
			ACT_DATA: begin
				desc.kind      = K_DATA;
				desc.opcode    = bitrev_q ? rev8(req.data_byte) : req.data_byte;
				desc.tail_poll = (chunk_left_q == CW'(1));
			end
			ACT_POLL_BUSY: desc.kind = K_POLL;
			ACT_FIN:       desc.kind = K_FIN;
			default:       desc.kind = K_ERR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			prog_q       <= 1'b0;
			cur_q        <= '0;
			rem_q        <= '0;
			chunk_left_q <= '0;
		end else if (push) begin
			phase_q <= phase_d;
			unique case (act) inside
				ACT_ERASE: begin
					prog_q <= 1'b0;
					cur_q  <= in_addr;
					rem_q  <= '0;
				end
				ACT_PROG_START: begin
					prog_q       <= 1'b1;
					cur_q        <= in_addr;
					rem_q        <= req.length;
					chunk_left_q <= cnt;
				end
				ACT_PROG_NEXT: chunk_left_q <= cnt;
				ACT_READ_START, ACT_READ_NEXT: begin
					prog_q <= (act == ACT_READ_START) ? 1'b0 : prog_q;
					cur_q  <= addr_after;
					rem_q  <= rem_after;
				end
				ACT_DATA: begin
					chunk_left_q <= chunk_left_q - CW'(1);
					rem_q        <= rem_q - 24'd1;
					cur_q        <= (cur_q + 24'd1) & AMASK;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_q   <= 1'b1;
			bitrev_q <= 1'b0;
		end else if (cfg.valid) begin
			if (cfg.reg_index == REG_FAST_READ) fast_q   <= cfg.reg_data;
			if (cfg.reg_index == REG_BIT_REV)   bitrev_q <= cfg.reg_data;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/snfcs_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SPI NOR command sequencer descriptor queue
// Short first-in first-out queue that decouples the front end from the frame
// generator.
// ----------------------------------------------------------------------------
module snfcs_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  snfcs_pkg::desc_t wr_desc,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output snfcs_pkg::desc_t head
);
	import snfcs_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	desc_t            store_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) store_q[wr_ptr_q] <= wr_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop)      count_q <= count_q + CNT_W'(1);
			else if (pop && !push) count_q <= count_q - CNT_W'(1);
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/snfcs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SPI NOR command sequencer frame generator
// Expands each descriptor into its frame bytes, one result word per cycle when
// res.ready allows, through an output register.
// ----------------------------------------------------------------------------
module snfcs_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  snfcs_pkg::desc_t head,
	output logic             pop,
	snfcs_res_if.source      res
);
	import snfcs_pkg::*;

	logic [2:0] step_q;
	logic       out_valid_q;
	res_t       out_q;
	res_t       elem;
	logic       advance;

	// Result word for the current step of the head descriptor.
	always_comb begin
		elem          = '0;
		elem.tx_valid = 1'b1;
		unique case (head.kind) inside
			K_ERR: begin
				elem.tx_valid    = 1'b0;
				elem.status_code = ST_SEQ;
				elem.last        = 1'b1;
			end
			K_FIN: begin
				elem.tx_valid = 1'b0;
				elem.done_res = 1'b1;
				elem.last     = 1'b1;
			end
			K_POLL: begin
				elem.tx_byte   = FOP_RDSR;
				elem.frame_end = 1'b1;
				elem.rx_count  = RX_RDSR;
				elem.last      = 1'b1;
			end
			K_RDID: begin
				elem.tx_byte   = FOP_RDID;
				elem.frame_end = 1'b1;
				elem.rx_count  = RX_RDID;
				elem.done_res  = 1'b1;
				elem.last      = 1'b1;
			end
			K_UID: begin
				case (step_q) inside
					3'd0: elem.tx_byte = FOP_RUID;
					3'd1, 3'd2, 3'd3: elem.tx_byte = 8'h00;
					default: begin
						elem.frame_end = 1'b1;
						elem.rx_count  = RX_RUID;
						elem.done_res  = 1'b1;
						elem.last      = 1'b1;
					end
				endcase
			end
			K_ERASE_CHIP: begin
				case (step_q)
					3'd0: begin
						elem.tx_byte   = FOP_WREN;
						elem.frame_end = 1'b1;
					end
					3'd1: begin
						elem.tx_byte   = FOP_CE;
						elem.frame_end = 1'b1;
					end
					default: begin
						elem.tx_byte   = FOP_RDSR;
						elem.frame_end = 1'b1;
						elem.rx_count  = RX_RDSR;
						elem.last      = 1'b1;
					end
				endcase
			end
			K_ERASE, K_PROG: begin
				case (step_q)
					3'd0: begin
						elem.tx_byte   = FOP_WREN;
						elem.frame_end = 1'b1;
					end
					3'd1: elem.tx_byte = (head.kind == K_ERASE) ? head.opcode : FOP_PP;
					3'd2: elem.tx_byte = head.addr[23:16];
					3'd3: elem.tx_byte = head.addr[15:8];
					3'd4: begin
						// An erase always polls; a program polls only on an empty chunk.
						elem.tx_byte   = head.addr[7:0];
						elem.frame_end = (head.kind == K_ERASE) || head.tail_poll;
						elem.last      = !elem.frame_end;
					end
					default: begin
						elem.tx_byte   = FOP_RDSR;
						elem.frame_end = 1'b1;
						elem.rx_count  = RX_RDSR;
						elem.last      = 1'b1;
					end
				endcase
			end
			K_READ: begin
				case (step_q)
					3'd0: elem.tx_byte = head.opcode;
					3'd1: elem.tx_byte = head.addr[23:16];
					3'd2: elem.tx_byte = head.addr[15:8];
					3'd3: begin
						elem.tx_byte   = head.addr[7:0];
						elem.frame_end = !head.dummy;
						elem.rx_count  = head.dummy ? 9'd0 : head.rx;
						elem.done_res  = !head.dummy && head.fin;
						elem.last      = !head.dummy;
					end
					default: begin
						elem.tx_byte   = 8'h00;
						elem.frame_end = 1'b1;
						elem.rx_count  = head.rx;
						elem.done_res  = head.fin;
						elem.last      = 1'b1;
					end
				endcase
			end
			K_DATA: begin
				case (step_q)
					3'd0: begin
						elem.tx_byte   = head.opcode;
						elem.frame_end = head.tail_poll;
						elem.last      = !head.tail_poll;
					end
					default: begin
						elem.tx_byte   = FOP_RDSR;
						elem.frame_end = 1'b1;
						elem.rx_count  = RX_RDSR;
						elem.last      = 1'b1;
					end
				endcase
			end
			default: begin
				elem.tx_valid    = 1'b0;
				elem.status_code = ST_SEQ;
				elem.last        = 1'b1;
			end
		endcase
	end

	assign advance = head_valid && (!out_valid_q || res.ready);
	assign pop     = advance && elem.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				step_q      <= elem.last ? 3'd0 : step_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) out_q <= elem;
	end

	assign res.valid       = out_valid_q;
	assign res.tx_valid    = out_q.tx_valid;
	assign res.tx_byte     = out_q.tx_byte;
	assign res.frame_end   = out_q.frame_end;
	assign res.rx_count    = out_q.rx_count;
	assign res.done_res    = out_q.done_res;
	assign res.status_code = out_q.status_code;
	assign res.last        = out_q.last;

endmodule
`default_nettype wire
